// ===== hdl/psf_pkg.sv =====
`timescale 1ns / 1ps
package psf_pkg;

  localparam int CFG_W         = 32;
  localparam int ADDR_W        = 5;
  localparam int COORD_FIELD_W = 32;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS     = 16;
  localparam int QUO_W         = 32;
  localparam int FORCE_W       = 32;

  localparam logic [CFG_W-1:0] RST_REST_BB   = 32'd32768;
  localparam logic [CFG_W-1:0] RST_REST_RUNG = 32'd72090;
  localparam logic [CFG_W-1:0] RST_BOND_K    = 32'd6553600;
  localparam logic [CFG_W-1:0] RST_HARD_K    = 32'd6553600;
  localparam logic [CFG_W-1:0] RST_CUTOFF    = 32'd26214;

  localparam logic [QUO_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [QUO_W-1:0] NEG_LIMIT = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_BACKBONE = 2'd0,
    CMD_RUNG     = 2'd1,
    CMD_NONBOND  = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_REST_BB   = 3'd0,
    REG_REST_RUNG = 3'd1,
    REG_BOND_K    = 3'd2,
    REG_HARD_K    = 3'd3,
    REG_CUTOFF    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]   rest_bb;
    logic [CFG_W-1:0]   rest_rung;
    logic [CFG_W-1:0]   bond_k;
    logic [CFG_W-1:0]   hard_k;
    logic [CFG_W-1:0]   cutoff;
    logic [2*CFG_W-1:0] cutoff_sq;
  } cfg_t;

endpackage

// ===== hdl/psf_cfg.sv =====
`timescale 1ns / 1ps
module psf_cfg import psf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [CFG_W-1:0]   rest_bb, rest_rung, bond_k, hard_k, cutoff;
  logic [2*CFG_W-1:0] cutoff_sq;
  reg_idx_t           idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_bb   <= RST_REST_BB;
      rest_rung <= RST_REST_RUNG;
      bond_k    <= RST_BOND_K;
      hard_k    <= RST_HARD_K;
      cutoff    <= RST_CUTOFF;
    end else if (wr) begin
      case (idx)
        REG_REST_BB:   rest_bb   <= pwdata;
        REG_REST_RUNG: rest_rung <= pwdata;
        REG_BOND_K:    bond_k    <= pwdata;
        REG_HARD_K:    hard_k    <= pwdata;
        REG_CUTOFF:    cutoff    <= pwdata;
        default: ;
      endcase
    end
  end

  // squared cutoff is a registered copy of the cutoff register, squared
  always_ff @(posedge clk) begin
    cutoff_sq <= (2*CFG_W)'(cutoff) * (2*CFG_W)'(cutoff);
  end

  always_comb begin
    case (idx)
      REG_REST_BB:   prdata = rest_bb;
      REG_REST_RUNG: prdata = rest_rung;
      REG_BOND_K:    prdata = bond_k;
      REG_HARD_K:    prdata = hard_k;
      REG_CUTOFF:    prdata = cutoff;
      default:       prdata = '0;
    endcase
  end

  assign cfg = '{rest_bb: rest_bb, rest_rung: rest_rung, bond_k: bond_k,
                 hard_k: hard_k, cutoff: cutoff, cutoff_sq: cutoff_sq};

endmodule

// ===== hdl/psf_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module psf_sqrt import psf_pkg::*; #(
  parameter int IN_W   = 66,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     in_rad,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int RW    = IN_W / 2;
  localparam int REM_W = RW + 2;

  logic              vld  [1:RW];
  logic [REM_W-1:0]  rem  [1:RW];
  logic [RW-1:0]     root [1:RW];
  logic [IN_W-1:0]   rad  [1:RW];
  logic [SIDE_W-1:0] side [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic              cur_vld;
    logic [REM_W-1:0]  cur_rem, cat, trial;
    logic [RW-1:0]     cur_root;
    logic [IN_W-1:0]   cur_rad;
    logic [SIDE_W-1:0] cur_side;
    logic              ge;

    if (k == 0) begin : g_first
      assign cur_vld  = in_valid;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_rad  = in_rad;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_vld  = vld[k];
      assign cur_rem  = rem[k];
      assign cur_root = root[k];
      assign cur_rad  = rad[k];
      assign cur_side = side[k];
    end

    assign cat   = {cur_rem[REM_W-3:0], cur_rad[IN_W-1 -: 2]};
    assign trial = {cur_root, 2'b01};
    assign ge    = (cat >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? (cat - trial) : cat;
        root[k+1] <= {cur_root[RW-2:0], ge};
        rad[k+1]  <= {cur_rad[IN_W-3:0], 2'b00};
        side[k+1] <= cur_side;
      end
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = root[RW];
  assign out_side  = side[RW];

endmodule

// ===== hdl/psf_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider with a QUO_W-bit quotient; overflow flagged up front.
module psf_div import psf_pkg::*; #(
  parameter int NUM_W  = 97,
  parameter int DEN_W  = 49,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo,
  output logic              out_ovf,
  output logic [SIDE_W-1:0] out_side
);

  localparam int HI_W = NUM_W - QUO_W;

  logic              vld  [0:QUO_W];
  logic              ovf  [0:QUO_W];
  logic [DEN_W-1:0]  rem  [0:QUO_W];
  logic [QUO_W-1:0]  low  [0:QUO_W];
  logic [DEN_W-1:0]  den  [0:QUO_W];
  logic [SIDE_W-1:0] side [0:QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf[0]  <= (in_num[NUM_W-1:QUO_W] >= HI_W'(in_den));
      rem[0]  <= in_num[QUO_W+DEN_W-1:QUO_W];
      low[0]  <= in_num[QUO_W-1:0];
      den[0]  <= in_den;
      side[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W:0] cat, diff;
    logic           ge;

    assign cat  = {rem[k], low[k][QUO_W-1]};
    assign diff = cat - {1'b0, den[k]};
    assign ge   = (cat >= {1'b0, den[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
        low[k+1]  <= {low[k][QUO_W-2:0], ge};
        ovf[k+1]  <= ovf[k];
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[QUO_W];
  assign out_quo   = low[QUO_W];
  assign out_ovf   = ovf[QUO_W];
  assign out_side  = side[QUO_W];

endmodule

// ===== hdl/psf_skid.sv =====
`timescale 1ns / 1ps
// Output register plus one skid entry; ready is a register.
module psf_skid import psf_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         ready,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;
  logic         push, pop;

  assign ready = ~skid_valid;
  assign push  = in_valid & ~skid_valid;
  assign pop   = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end
  end

endmodule

// ===== hdl/pair_spring_force_top.sv =====
`timescale 1ns / 1ps
// Pair force for a bead-spring model: takes one pair per beat (command in s_tuser, six
// signed Q15.16 coordinates in s_tdata) and returns the force on the second bead as
// signed Q15.16, saturated, with acting/degenerate/saturated flags in m_tuser. Throughput
// is one pair per clock while the output is not stalled. The pipeline is the bit-per-stage
// square root (CW + 1 stages, CW being COORD_WIDTH clamped to 16..32), the 33-stage
// divider, eight arithmetic stages and the output register.
// Backpressure stalls the whole pipeline; a skid entry keeps s_tready a register.
// Configuration writes should be made while no pair is in flight.
module pair_spring_force_top import psf_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // s_tdata: first_x, first_y, first_z, second_x, second_y, second_z
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [6*COORD_FIELD_W-1:0] s_tdata,
  // s_tuser: command
  input  logic [1:0]               s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // m_tdata: force_x, force_y, force_z
  output logic [3*FORCE_W-1:0]     m_tdata,
  // m_tuser: acting, degenerate, saturated
  output logic [2:0]               m_tuser,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [CFG_W-1:0]         pwdata,
  output logic [CFG_W-1:0]         prdata,
  output logic                     pready
);

  // coordinate width is clamped between 16 and the field width
  localparam int CW   = (COORD_WIDTH < 16) ? 16 :
                        ((COORD_WIDTH > COORD_FIELD_W) ? COORD_FIELD_W : COORD_WIDTH);
  localparam int MW   = CW;            // |d|
  localparam int DW   = CW + 1;        // d, signed
  localparam int SQW  = 2 * MW;        // d^2
  localparam int R2W  = SQW + 2;       // sum of three squares
  localparam int NW   = R2W / 2;       // distance
  localparam int SMW  = (NW > CFG_W) ? NW : CFG_W;   // |n - L|
  localparam int SDW  = SMW + 1;
  localparam int PW   = MW + SMW;      // |d| * |s|
  localparam int NUMW = PW + CFG_W;    // times stiffness
  localparam int DENW = NW + FRAC_BITS;
  localparam int CMPW = (R2W > 2*CFG_W) ? R2W : 2*CFG_W;
  localparam int SQ_SIDE_W = 3*MW + 7;
  localparam int OUT_W = 3*FORCE_W + 3;

  cfg_t cfg;
  logic en;

  psf_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign s_tready = en;

  // stage 1: differences
  logic                  v1;
  cmd_t                  cmd1;
  logic signed [DW-1:0]  d1 [3];
  logic signed [DW-1:0]  d_in [3];

  for (genvar i = 0; i < 3; i++) begin : g_diff
    logic [CW-1:0] ca, cb;
    assign ca = s_tdata[i*COORD_FIELD_W +: CW];
    assign cb = s_tdata[(i+3)*COORD_FIELD_W +: CW];
    assign d_in[i] = $signed({ca[CW-1], ca}) - $signed({cb[CW-1], cb});
  end

  // stages 2..4: magnitudes, squares, sum
  logic            v2, v3, v4;
  cmd_t            cmd2, cmd3, cmd4;
  logic [MW-1:0]   mag2 [3];
  logic [MW-1:0]   mag3 [3];
  logic [MW-1:0]   mag4 [3];
  logic [2:0]      neg2, neg3, neg4;
  logic [SQW-1:0]  sq3 [3];
  logic [R2W-1:0]  r2_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= cmd_t'(s_tuser);
      cmd2 <= cmd1;
      cmd3 <= cmd2;
      cmd4 <= cmd3;
      neg3 <= neg2;
      neg4 <= neg3;
      for (int i = 0; i < 3; i++) begin
        d1[i]   <= d_in[i];
        neg2[i] <= d1[i][DW-1];
        mag2[i] <= d1[i][DW-1] ? MW'(-d1[i]) : MW'(d1[i]);
        sq3[i]  <= SQW'(mag2[i]) * SQW'(mag2[i]);
        mag3[i] <= mag2[i];
        mag4[i] <= mag3[i];
      end
      r2_4 <= R2W'(sq3[0]) + R2W'(sq3[1]) + R2W'(sq3[2]);
    end
  end

  // flags ride alongside the root
  logic zero4, below4, acting4, degen4;
  logic [SQ_SIDE_W-1:0] sq_side_in, sq_side;
  logic                 sq_valid;
  logic [NW-1:0]        n_s;

  assign zero4   = (r2_4 == '0);
  assign below4  = (CMPW'(r2_4) < CMPW'(cfg.cutoff_sq));
  assign degen4  = (cmd4 != CMD_UNUSED) && zero4;
  assign acting4 = (cmd4 != CMD_UNUSED) && !zero4 && ((cmd4 != CMD_NONBOND) || below4);
  assign sq_side_in = {mag4[2], mag4[1], mag4[0], neg4,
                       (cmd4 == CMD_RUNG), (cmd4 == CMD_NONBOND), degen4, acting4};

  psf_sqrt #(.IN_W(R2W), .SIDE_W(SQ_SIDE_W)) u_sqrt (
    .clk, .rst, .en,
    .in_valid (v4),
    .in_rad   (r2_4),
    .in_side  (sq_side_in),
    .out_valid(sq_valid),
    .out_root (n_s),
    .out_side (sq_side)
  );

  logic                  acting_s, degen_s, nb_s, rung_s;
  logic [2:0]            neg_s;
  logic [MW-1:0]         mag_s [3];
  logic [CFG_W-1:0]      rest_s;
  logic signed [SDW-1:0] sdiff;

  assign acting_s = sq_side[0];
  assign degen_s  = sq_side[1];
  assign nb_s     = sq_side[2];
  assign rung_s   = sq_side[3];
  assign neg_s    = sq_side[6:4];
  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign mag_s[i] = sq_side[7 + i*MW +: MW];
  end

  assign rest_s = nb_s ? cfg.cutoff : (rung_s ? cfg.rest_rung : cfg.rest_bb);
  assign sdiff  = $signed(SDW'(n_s)) - $signed(SDW'(rest_s));

  // stages 5..8: spring extension, products, numerator
  logic              v5, v6, v7, v8;
  logic              acting5, acting6, acting7, acting8;
  logic              degen5, degen6, degen7, degen8;
  logic              nb5, sneg5, sneg6;
  logic [SMW-1:0]    smag5;
  logic [DENW-1:0]   den5, den6, den7, den8;
  logic [2:0]        neg5, neg6, fneg7, fneg8;
  logic [MW-1:0]     mag5 [3];
  logic [PW-1:0]     p6 [3];
  logic [CFG_W-1:0]  stiff6;
  logic [2*CFG_W-1:0] mlo7 [3];
  logic [PW-1:0]     mhi7 [3];
  logic [NUMW-1:0]   num8 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v5 <= sq_valid;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acting5 <= acting_s;
      degen5  <= degen_s;
      nb5     <= nb_s;
      neg5    <= neg_s;
      sneg5   <= sdiff[SDW-1];
      smag5   <= sdiff[SDW-1] ? SMW'(-sdiff) : SMW'(sdiff);
      den5    <= {n_s, {FRAC_BITS{1'b0}}};

      acting6 <= acting5;
      degen6  <= degen5;
      neg6    <= neg5;
      sneg6   <= sneg5;
      den6    <= den5;
      stiff6  <= nb5 ? cfg.hard_k : cfg.bond_k;

      acting7 <= acting6;
      degen7  <= degen6;
      fneg7   <= neg6 ^ {3{sneg6}};
      den7    <= den6;

      acting8 <= acting7;
      degen8  <= degen7;
      fneg8   <= fneg7;
      den8    <= den7;

      for (int i = 0; i < 3; i++) begin
        mag5[i] <= mag_s[i];
        p6[i]   <= PW'(mag5[i]) * PW'(smag5);
        // product by stiffness split in two halves
        mlo7[i] <= (2*CFG_W)'(p6[i][CFG_W-1:0]) * (2*CFG_W)'(stiff6);
        mhi7[i] <= PW'(p6[i][PW-1:CFG_W]) * PW'(stiff6);
        num8[i] <= NUMW'(mlo7[i]) + {mhi7[i], {CFG_W{1'b0}}};
      end
    end
  end

  // dividers: |F| = num / (n << 16)
  logic             dv_valid [3];
  logic [QUO_W-1:0] quo [3];
  logic             ovf [3];
  logic [2:0]       side_x;
  logic             side_y, side_z;

  psf_div #(.NUM_W(NUMW), .DEN_W(DENW), .SIDE_W(3)) u_div_x (
    .clk, .rst, .en,
    .in_valid (v8), .in_num(num8[0]), .in_den(den8),
    .in_side  ({fneg8[0], degen8, acting8}),
    .out_valid(dv_valid[0]), .out_quo(quo[0]), .out_ovf(ovf[0]), .out_side(side_x)
  );

  psf_div #(.NUM_W(NUMW), .DEN_W(DENW), .SIDE_W(1)) u_div_y (
    .clk, .rst, .en,
    .in_valid (v8), .in_num(num8[1]), .in_den(den8),
    .in_side  (fneg8[1]),
    .out_valid(dv_valid[1]), .out_quo(quo[1]), .out_ovf(ovf[1]), .out_side(side_y)
  );

  psf_div #(.NUM_W(NUMW), .DEN_W(DENW), .SIDE_W(1)) u_div_z (
    .clk, .rst, .en,
    .in_valid (v8), .in_num(num8[2]), .in_den(den8),
    .in_side  (fneg8[2]),
    .out_valid(dv_valid[2]), .out_quo(quo[2]), .out_ovf(ovf[2]), .out_side(side_z)
  );

  // signed saturation and masking
  logic             acting_d, degen_d;
  logic [2:0]       fneg_d, clip;
  logic [FORCE_W-1:0] force_v [3];
  logic             valid_d;

  assign acting_d = side_x[0];
  assign degen_d  = side_x[1];
  assign fneg_d   = {side_z, side_y, side_x[2]};
  assign valid_d  = dv_valid[0] & dv_valid[1] & dv_valid[2];

  for (genvar i = 0; i < 3; i++) begin : g_sat
    logic [QUO_W-1:0] limit, m;
    logic             over;
    assign limit = fneg_d[i] ? NEG_LIMIT : POS_LIMIT;
    assign over  = ovf[i] || (quo[i] > limit);
    assign m     = over ? limit : quo[i];
    assign clip[i]    = acting_d & over;
    assign force_v[i] = acting_d ? (fneg_d[i] ? FORCE_W'(-m) : FORCE_W'(m)) : '0;
  end

  logic [OUT_W-1:0] out_data;

  psf_skid #(.W(OUT_W)) u_skid (
    .clk, .rst,
    .in_valid (valid_d),
    .in_data  ({(|clip), degen_d, acting_d, force_v[2], force_v[1], force_v[0]}),
    .ready    (en),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_data)
  );

  assign m_tdata = out_data[3*FORCE_W-1:0];
  assign m_tuser = out_data[OUT_W-1:3*FORCE_W];

  // a stalled pipeline always has a result waiting at the output
  a_stall_has_out: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid) else $error("stall without pending result");

  a_sat_needs_act: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[0]) else $error("saturated without acting");

  a_degen_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[1] && m_tuser[0])) else $error("degenerate and acting");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == '0)) else $error("force without acting");

endmodule

// ===== tb/tb_pair_spring_force_top.sv =====
`timescale 1ns / 1ps
module tb_pair_spring_force_top;
  import psf_pkg::*;

  // Beats in flight from sender: command plus six coordinates, first_x in pos[0].
  typedef struct {
    cmd_t             cmd;
    logic [5:0][31:0] pos;
  } pair_t;

  // Expected force beat: force_x in f[0]; flags as in m_tuser.
  typedef struct {
    logic [2:0][31:0] f;
    logic             acting;
    logic             degen;
    logic             sat;
  } force_t;

  // Register index that decodes to nothing; writes to it must be ignored.
  localparam logic [2:0] REG_UNMAPPED = 3'd6;
  localparam int         STALL_LIMIT  = 4000;  // cycles with no beat on either side
  localparam int         DRAIN_CYCLES = 120;   // long enough to flush the pipeline
  localparam int         HOLD_CYCLES  = 400;   // long receiver hold-off

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [6*COORD_FIELD_W-1:0] s_tdata = '0;
  logic [1:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [3*FORCE_W-1:0]   m_tdata;
  logic [2:0]             m_tuser;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [CFG_W-1:0]       pwdata = '0;
  logic [CFG_W-1:0]       prdata;
  logic                   pready;

  pair_spring_force_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // Local copy of the register file, indexed by reg_idx_t.
  logic [31:0] cfg_copy [0:4];

  pair_t  pair_q [$];     // pairs waiting for the driver
  force_t force_q [$];    // predicted forces awaiting the output side
  pair_t  offered;
  bit     loaded = 0;
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_reqs = 0;
  int     hold_done = 0;
  int     hold_left = 0;
  int     quiet_cycles = 0;

  // Exact pair force: d = first - second, n = floor(|d|), F = d/n * (n - L) * k,
  // truncated toward zero and clipped per component.
  function automatic force_t pair_force(pair_t p);
    force_t       r;
    logic [32:0]  d [3];
    logic [32:0]  m [3];
    logic [67:0]  r2;
    logic [33:0]  n;
    logic [33:0]  t;
    logic [35:0]  s;
    logic [35:0]  smag;
    logic [31:0]  rest;
    logic [31:0]  stiff;
    logic [127:0] q;
    logic [31:0]  limit;
    logic         neg;
    logic         active;
    r = '{f: '0, acting: 0, degen: 0, sat: 0};
    r2 = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = {p.pos[i][31], p.pos[i]} - {p.pos[i+3][31], p.pos[i+3]};
      m[i] = d[i][32] ? -d[i] : d[i];
      r2 += 68'(m[i]) * 68'(m[i]);
    end
    if (p.cmd == CMD_UNUSED) return r;
    if (r2 == 0) begin
      r.degen = 1;
      return r;
    end
    active = 1;
    case (p.cmd)
      CMD_BACKBONE: begin
        rest = cfg_copy[REG_REST_BB];
        stiff = cfg_copy[REG_BOND_K];
      end
      CMD_RUNG: begin
        rest = cfg_copy[REG_REST_RUNG];
        stiff = cfg_copy[REG_BOND_K];
      end
      default: begin
        rest = cfg_copy[REG_CUTOFF];
        stiff = cfg_copy[REG_HARD_K];
        active = r2 < 68'(rest) * 68'(rest);
      end
    endcase
    if (!active) return r;
    n = '0;
    for (int b = 33; b >= 0; b--) begin
      t = n | (34'd1 << b);
      if (68'(t) * 68'(t) <= r2) n = t;
    end
    s = {2'b0, n} - {4'b0, rest};
    smag = s[35] ? -s : s;
    r.acting = 1;
    for (int i = 0; i < 3; i++) begin
      q = (128'(m[i]) * 128'(smag) * 128'(stiff)) / 128'({n, 16'b0});
      neg = d[i][32] != s[35];
      limit = neg ? NEG_LIMIT : POS_LIMIT;
      if (q > 128'(limit)) begin
        q = 128'(limit);
        r.sat = 1;
      end
      r.f[i] = neg ? -q[31:0] : q[31:0];
    end
    return r;
  endfunction

  // Sender: offered pair held until accepted; prediction taken at the accepting edge.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        force_q.push_back(pair_force(offered));
        loaded = 0;
      end
      if (!loaded && pair_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = pair_q.pop_front();
        loaded = 1;
      end
      s_tvalid <= loaded;
      s_tdata <= offered.pos;
      s_tuser <= offered.cmd;
    end
  end

  // Receiver: random stall, plus a long hold-off on request to back the pipe up.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 0;
    end else if (hold_done != hold_reqs) begin
      hold_done <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      m_tready <= 0;
    end else begin
      m_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Output checker
  always @(posedge clk) begin
    force_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (force_q.size() == 0) begin
        $display("%0t: force beat with nothing expected: tdata %h tuser %b",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        e = force_q.pop_front();
        for (int i = 0; i < 3; i++)
          if (m_tdata[32*i +: 32] !== e.f[i]) begin
            $display("%0t: force[%0d] expected %h actual %h", $time, i, e.f[i],
                     m_tdata[32*i +: 32]);
            errors++;
          end
        if (m_tuser !== {e.sat, e.degen, e.acting}) begin
          $display("%0t: flags sat/degen/acting expected %b actual %b", $time,
                   {e.sat, e.degen, e.acting}, m_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog on beat activity
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_pair(cmd_t cmd, logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                          logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    pair_t p;
    p.cmd = cmd;
    p.pos = {sz, sy, sx, fz, fy, fx};
    pair_q.push_back(p);
  endtask

  // Mostly close pairs at random scales; some far-flung, some coincident.
  task automatic add_random_pairs(int count);
    pair_t p;
    int    sh;
    for (int k = 0; k < count; k++) begin
      p.cmd = cmd_t'($urandom_range(9) == 0 ? CMD_UNUSED : $urandom_range(2));
      for (int i = 0; i < 3; i++) p.pos[i] = $urandom;
      case ($urandom_range(9))
        0: for (int i = 3; i < 6; i++) p.pos[i] = $urandom;
        1: for (int i = 3; i < 6; i++) p.pos[i] = p.pos[i-3];
        default: begin
          sh = $urandom_range(20, 8);
          for (int i = 3; i < 6; i++)
            p.pos[i] = p.pos[i-3] + ($signed($urandom) >>> (31 - sh));
        end
      endcase
      pair_q.push_back(p);
    end
  endtask

  // APB write: setup then access; the model copy follows only for mapped indexes.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx <= REG_CUTOFF) cfg_copy[idx] = val;
  endtask

  task automatic write_all(logic [31:0] rbb, logic [31:0] rr, logic [31:0] bk,
                           logic [31:0] hk, logic [31:0] cut);
    write_reg(REG_REST_BB, rbb);
    write_reg(REG_REST_RUNG, rr);
    write_reg(REG_BOND_K, bk);
    write_reg(REG_HARD_K, hk);
    write_reg(REG_CUTOFF, cut);
  endtask

  // Wait until every queued pair is through and the pipe has flushed.
  task automatic drain();
    do @(posedge clk); while (pair_q.size() > 0 || loaded || force_q.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    cfg_copy[REG_REST_BB] = RST_REST_BB;
    cfg_copy[REG_REST_RUNG] = RST_REST_RUNG;
    cfg_copy[REG_BOND_K] = RST_BOND_K;
    cfg_copy[REG_HARD_K] = RST_HARD_K;
    cfg_copy[REG_CUTOFF] = RST_CUTOFF;
    repeat (11) @(posedge clk);
    rst <= 0;

    // Directed, reset values, no idling.
    add_pair(CMD_BACKBONE, 0, 0, 0, 32'd65536, 0, 0);          // stretched bond
    add_pair(CMD_BACKBONE, 0, 0, 0, 32'd16384, 0, 0);          // compressed bond
    add_pair(CMD_RUNG, 32'd65536, 32'd65536, 0, 0, 0, 32'd65536);
    add_pair(CMD_RUNG, 0, 0, 0, 0, 32'd72090, 0);              // at rest length
    add_pair(CMD_NONBOND, 0, 0, 0, 32'd13107, 0, 0);           // inside cutoff
    add_pair(CMD_NONBOND, 0, 0, 0, 0, 0, 32'd26214);           // exactly at cutoff
    add_pair(CMD_NONBOND, 0, 0, 0, 32'd65536, 0, 0);           // outside cutoff
    add_pair(CMD_NONBOND, 32'd5000, -32'd3000, 32'd1000, -32'd2000, 32'd4000, 0);
    for (int c = 0; c < 4; c++)                                 // coinciding beads
      add_pair(cmd_t'(c), 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
    add_pair(CMD_UNUSED, 0, 0, 0, 32'd65536, 32'd65536, 0);
    for (int c = 0; c < 3; c++) begin                           // coordinate extremes
      add_pair(cmd_t'(c), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_pair(cmd_t'(c), 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    end
    add_pair(CMD_BACKBONE, -32'd1, -32'd1, -32'd1, 0, 0, 0);  // tiny separation
    add_random_pairs(230);
    drain();

    // Zero stiffness, zero lengths; unmapped write must leave the registers alone.
    write_all(0, 0, 0, 0, 0);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_idle_pct = 72;
    add_pair(CMD_BACKBONE, 0, 0, 0, 32'd65536, 0, 0);
    add_random_pairs(150);
    drain();

    // All-ones extremes
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_stall_pct = 72;
    add_random_pairs(150);
    drain();

    // Moderate random settings; long receiver hold-off while the sender keeps going.
    write_all($urandom_range(32'h3FFFF), $urandom_range(32'h3FFFF),
              $urandom_range(32'hFFFFFF), $urandom_range(32'hFFFFFF),
              $urandom_range(32'h1FFFF));
    recv_stall_pct = 0;
    add_random_pairs(150);
    hold_reqs++;
    repeat (HOLD_CYCLES / 2) @(posedge clk);
    send_idle_pct = 31;
    recv_stall_pct = 31;
    add_random_pairs(150);
    drain();

    // Fully random settings, no idling
    write_all($urandom, $urandom, $urandom, $urandom, $urandom);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_random_pairs(300);
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
